// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the RTL. Each macro samples on the rising
// edge of clk and is disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Check that an expression holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed");

// Check that a consequent holds in the same cycle as its antecedent.
`define ASSERT_IMPLIES(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Check that a consequent holds in the cycle after its antecedent.
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define ASSERT_ALWAYS(label, expr)
`define ASSERT_IMPLIES(label, ante, cons)
`define ASSERT_NEXT(label, ante, cons)

`endif

`endif

// ===== hw/rtl/ifs_fern_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fern point step package
// Map codes, affine coefficients, register codes and fixed-point helpers for
// the chaos-game fern point generator.
// ----------------------------------------------------------------------------
package ifs_fern_pkg;

    // Image window size; both are powers of two in this build.
    localparam int IMG_W = 2048;
    localparam int IMG_H = 1024;
    localparam int COL_W = 11;
    localparam int ROW_W = 10;

    // Point format is signed Q7.24.
    localparam int FRAC_BITS = 24;

    // Register reset values and the largest legal draw.
    localparam logic [6:0] LIMIT_STEM_RST = 7'd2;
    localparam logic [6:0] LIMIT_MAIN_RST = 7'd86;
    localparam logic [6:0] LIMIT_LEFT_RST = 7'd93;
    localparam logic [6:0] DRAW_MAX       = 7'd99;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        CFG_LIMIT_STEM = 2'd0,
        CFG_LIMIT_MAIN = 2'd1,
        CFG_LIMIT_LEFT = 2'd2,
        CFG_UNUSED     = 2'd3
    } cfg_index_t;

    // Affine map codes.
    typedef enum logic [1:0] {
        MAP_STEM  = 2'd0,
        MAP_MAIN  = 2'd1,
        MAP_LEFT  = 2'd2,
        MAP_RIGHT = 2'd3
    } map_t;

    // Coefficients are signed Q.24; the x offset is zero for every map.
    typedef logic signed [25:0] coef_t;

    typedef struct packed {
        coef_t a;
        coef_t b;
        coef_t c;
        coef_t d;
        coef_t f;
    } map_coef_t;

    // Pixel mapping: column spans x in -2.5..2.5, row spans y in 0..10.
    localparam logic signed [32:0] COL_OFFSET = 33'sd41943040;   // 2.5
    localparam logic signed [32:0] COL_SPAN   = 33'sd83886080;   // 5.0
    localparam logic signed [31:0] ROW_SPAN   = 32'sd167772160;  // 10.0
    localparam int COL_SHIFT = FRAC_BITS - $clog2(IMG_W);
    localparam int ROW_SHIFT = FRAC_BITS - $clog2(IMG_H);

    // Reciprocal multipliers: floor(v/5) and floor(v/10) for v below 10240.
    localparam logic [13:0] RECIP_MUL  = 14'd13108;
    localparam int          DIV5_SHIFT  = 16;
    localparam int          DIV10_SHIFT = 17;

    function automatic map_coef_t map_coef(input map_t m);
        map_coef_t k;
        case (m)
            MAP_STEM:  k = '{26'sd0, 26'sd0, 26'sd0, 26'sd3355443, -26'sd2013266};
            MAP_MAIN:  k = '{26'sd14176748, 26'sd587203, -26'sd587203,
                             26'sd13757317, 26'sd26843546};
            MAP_LEFT:  k = '{26'sd3355443, -26'sd5200937, 26'sd4278190,
                             26'sd4110418, 26'sd4865393};
            default:   k = '{-26'sd2516582, 26'sd4026532, 26'sd4194304,
                             26'sd3355443, 26'sd11408507};
        endcase
        return k;
    endfunction

    // Round a Q.48 sum to Q.24 (half up) and saturate to 32 bits.
    function automatic logic signed [31:0] round_sat(input logic signed [59:0] s);
        logic signed [59:0] t;
        logic signed [35:0] r;
        t = s + 60'sd8388608;
        r = t[59:24];
        if (r > 36'sd2147483647)
            return 32'sh7FFFFFFF;
        else if (r < -36'sd2147483648)
            return 32'sh80000000;
        else
            return r[31:0];
    endfunction

endpackage

// ===== hw/rtl/ifs_fern_point_step_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fern point step core
// Chaos-game fern generator: one random draw per request moves the stored
// point through one of four affine maps and reports the new point and pixel.
// ----------------------------------------------------------------------------
// Usage:
// Input requests carry one draw (0..99) on in_valid/in_ready. Each accepted
// request produces exactly one result on out_valid/out_ready with the new
// point, the map used, the pixel position and the in_frame and bad_draw flags.
// Draws above 99 set bad_draw, leave the point unchanged and zero the map
// and pixel fields.
// Throughput is one request per cycle while the receiver does not stall.
// From acceptance to out_valid, the first stage runs the 2x2 multiply-add
// that feeds back into the stored point, the second turns the point into
// a pixel with constant reciprocal multiplies.
// Reset clears the point to (0,0), loads the threshold registers with
// 2, 86 and 93 and empties both stages.
// When the receiver stalls, the result holds, the first stage fills, and
// in_ready then drops until out_ready returns.
// Thresholds are written on cfg_we with cfg_index/cfg_data; the user must
// do so only while idle, as the block does not enforce it. Index 3 is ignored.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ifs_fern_point_step_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [6:0]         cfg_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [6:0]         draw,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] point_x,
    output logic signed [31:0] point_y,
    output logic [1:0]         map_used,
    output logic [10:0]        pixel_col,
    output logic [9:0]         pixel_row,
    output logic               in_frame,
    output logic               bad_draw
);

    // Threshold registers.
    logic [6:0] limit_stem_reg;
    logic [6:0] limit_main_reg;
    logic [6:0] limit_left_reg;

    // Stored point; it also serves as the point of the first stage.
    logic signed [31:0] cur_x_reg;
    logic signed [31:0] cur_y_reg;
    logic signed [31:0] cur_x_next;
    logic signed [31:0] cur_y_next;

    // First stage control and payload.
    logic               s1_valid_reg;
    ifs_fern_pkg::map_t s1_map_reg;
    logic               s1_bad_reg;

    // Result register.
    logic               out_valid_reg;
    logic signed [31:0] point_x_reg;
    logic signed [31:0] point_y_reg;
    logic [1:0]         map_used_reg;
    logic [10:0]        pixel_col_reg;
    logic [9:0]         pixel_row_reg;
    logic               in_frame_reg;
    logic               bad_draw_reg;

    logic               advance;
    logic               accept;
    logic               draw_bad;
    ifs_fern_pkg::map_t map_sel;
    ifs_fern_pkg::map_coef_t coef;

    logic signed [57:0] prod_ax;
    logic signed [57:0] prod_by;
    logic signed [57:0] prod_cx;
    logic signed [57:0] prod_dy;
    logic signed [59:0] sum_x;
    logic signed [59:0] sum_y;

    logic signed [32:0] col_num;
    logic               col_ok;
    logic               row_ok;
    logic [13:0]        col_val;
    logic [13:0]        row_val;
    logic [27:0]        col_prod;
    logic [27:0]        row_prod;
    logic               frame_next;

    // Handshake: the result register moves when empty or taken.
    assign advance  = !out_valid_reg || out_ready;
    assign in_ready = !s1_valid_reg || advance;
    assign accept   = in_valid && in_ready;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_stem_reg <= ifs_fern_pkg::LIMIT_STEM_RST;
            limit_main_reg <= ifs_fern_pkg::LIMIT_MAIN_RST;
            limit_left_reg <= ifs_fern_pkg::LIMIT_LEFT_RST;
        end
        else if (cfg_we)
        begin
            unique case (ifs_fern_pkg::cfg_index_t'(cfg_index))
                ifs_fern_pkg::CFG_LIMIT_STEM: limit_stem_reg <= cfg_data;
                ifs_fern_pkg::CFG_LIMIT_MAIN: limit_main_reg <= cfg_data;
                ifs_fern_pkg::CFG_LIMIT_LEFT: limit_left_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Map selection in priority order stem, main, left. A bad draw reports
    // the stem code; the point is not moved in that case.
    always_comb
    begin
        draw_bad = (draw > ifs_fern_pkg::DRAW_MAX);
        if (draw_bad)
            map_sel = ifs_fern_pkg::MAP_STEM;
        else if (draw < limit_stem_reg)
            map_sel = ifs_fern_pkg::MAP_STEM;
        else if (draw < limit_main_reg)
            map_sel = ifs_fern_pkg::MAP_MAIN;
        else if (draw < limit_left_reg)
            map_sel = ifs_fern_pkg::MAP_LEFT;
        else
            map_sel = ifs_fern_pkg::MAP_RIGHT;
        coef = ifs_fern_pkg::map_coef(map_sel);
    end

    // Affine step: exact Q.48 sums, then round and saturate to Q.24.
    assign prod_ax = cur_x_reg * coef.a;
    assign prod_by = cur_y_reg * coef.b;
    assign prod_cx = cur_x_reg * coef.c;
    assign prod_dy = cur_y_reg * coef.d;
    assign sum_x   = 60'(prod_ax) + 60'(prod_by);
    assign sum_y   = 60'(prod_cx) + 60'(prod_dy)
                   + (60'(coef.f) <<< ifs_fern_pkg::FRAC_BITS);
    assign cur_x_next = ifs_fern_pkg::round_sat(sum_x);
    assign cur_y_next = ifs_fern_pkg::round_sat(sum_y);

    // Stored point; a bad draw leaves it as it is.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_x_reg <= '0;
            cur_y_reg <= '0;
        end
        else if (accept && !draw_bad)
        begin
            cur_x_reg <= cur_x_next;
            cur_y_reg <= cur_y_next;
        end
    end

    // First stage valid and payload.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_map_reg <= map_sel;
            s1_bad_reg <= draw_bad;
        end
    end

    // Pixel mapping with range checks and reciprocal division.
    always_comb
    begin
        col_num  = 33'(cur_x_reg) + ifs_fern_pkg::COL_OFFSET;
        col_ok   = !col_num[32] && (col_num < ifs_fern_pkg::COL_SPAN);
        row_ok   = !cur_y_reg[31] && (cur_y_reg < ifs_fern_pkg::ROW_SPAN);
        col_val  = 14'(col_num >>> ifs_fern_pkg::COL_SHIFT);
        row_val  = 14'(cur_y_reg >>> ifs_fern_pkg::ROW_SHIFT);
        col_prod = 28'(col_val) * 28'(ifs_fern_pkg::RECIP_MUL);
        row_prod = 28'(row_val) * 28'(ifs_fern_pkg::RECIP_MUL);
        frame_next = col_ok && row_ok && !s1_bad_reg;
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && s1_valid_reg)
        begin
            point_x_reg   <= cur_x_reg;
            point_y_reg   <= cur_y_reg;
            map_used_reg  <= s1_map_reg;
            bad_draw_reg  <= s1_bad_reg;
            in_frame_reg  <= frame_next;
            pixel_col_reg <= frame_next
                           ? 11'(col_prod >> ifs_fern_pkg::DIV5_SHIFT) : '0;
            pixel_row_reg <= frame_next
                           ? 10'(row_prod >> ifs_fern_pkg::DIV10_SHIFT) : '0;
        end
    end

    assign out_valid = out_valid_reg;
    assign point_x   = point_x_reg;
    assign point_y   = point_y_reg;
    assign map_used  = map_used_reg;
    assign pixel_col = pixel_col_reg;
    assign pixel_row = pixel_row_reg;
    assign in_frame  = in_frame_reg;
    assign bad_draw  = bad_draw_reg;

    // A bad draw reports map code zero (the stem code) and no pixel.
    `ASSERT_IMPLIES(a_bad_clean, out_valid_reg && bad_draw_reg, !in_frame_reg && map_used_reg == ifs_fern_pkg::MAP_STEM)
    // Pixel fields are zero outside the frame.
    `ASSERT_IMPLIES(a_pixel_zero, out_valid_reg && !in_frame_reg, pixel_col_reg == '0 && pixel_row_reg == '0)
    // A bad draw leaves the stored point unchanged.
    `ASSERT_NEXT(a_bad_holds_point, accept && (draw > ifs_fern_pkg::DRAW_MAX), $stable(cur_x_reg) && $stable(cur_y_reg))
    // With both stages full and the result stalled, no request is taken.
    `ASSERT_IMPLIES(a_full_blocks, s1_valid_reg && out_valid_reg && !out_ready, !in_ready)

endmodule

// ===== bench/ifs_fern_point_step_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fern point step core testbench
// Sends draws into the fern point step core under several idle and stall
// patterns and threshold settings. The bench keeps its own copy of the point
// and thresholds, works out each new point, map and pixel itself, and checks
// every result in order against that prediction.
// ----------------------------------------------------------------------------
module ifs_fern_point_step_core_tb;

    localparam int RUN_LIMIT    = 200000;
    localparam int CHUNK_ITEMS  = 112;
    localparam int MAX_REPORTS  = 10;
    localparam int TAIL_CYCLES  = 8;

    localparam logic [6:0] LAST_GOOD_DRAW = 7'd99;
    localparam longint Q24_ONE  = 64'sd16777216;
    localparam longint Q24_HALF = 64'sd8388608;
    localparam longint X_SHIFT  = 64'sd41943040;    // 2.5 in Q.24
    localparam longint X_SPAN   = 64'sd83886080;    // 5.0 in Q.24
    localparam longint Y_SPAN   = 64'sd167772160;   // 10.0 in Q.24

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        ifs_fern_pkg::map_t mp;
        logic [10:0]        col;
        logic [9:0]         row;
        logic               frame;
        logic               bad;
    } fern_result_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_we = 1'b0;
    logic [1:0]         cfg_index = ifs_fern_pkg::CFG_LIMIT_STEM;
    logic [6:0]         cfg_data = '0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic [6:0]         draw = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic [1:0]         map_used;
    logic [10:0]        pixel_col;
    logic [9:0]         pixel_row;
    logic               in_frame;
    logic               bad_draw;

    // Bench copy of the stored point and of the threshold registers.
    logic signed [31:0] pt_x = '0;
    logic signed [31:0] pt_y = '0;
    logic [6:0]         lim_stem = 7'd2;
    logic [6:0]         lim_main = 7'd86;
    logic [6:0]         lim_left = 7'd93;

    fern_result_t pending_points[$];
    int           mismatches = 0;
    int           results_seen = 0;
    int           cycle_count = 0;
    int           send_idle_pct = 0;
    int           recv_stall_pct = 0;

    ifs_fern_point_step_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .draw      (draw),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .point_x   (point_x),
        .point_y   (point_y),
        .map_used  (map_used),
        .pixel_col (pixel_col),
        .pixel_row (pixel_row),
        .in_frame  (in_frame),
        .bad_draw  (bad_draw)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Round a Q.48 sum half up to Q.24 and clamp it to 32 bits.
    function automatic logic signed [31:0] q48_round(input longint s);
        longint q;
        q = (s + Q24_HALF) >>> 24;
        if (q > 64'sd2147483647)
            return 32'sh7FFFFFFF;
        else if (q < -64'sd2147483648)
            return 32'sh80000000;
        else
            return q[31:0];
    endfunction

    // Move the bench point by one draw and return the result it should give.
    function automatic fern_result_t fern_advance(input logic [6:0] d);
        fern_result_t r;
        longint ka, kb, kc, kd, kf, xs, ys, cn, rn, cq, rq;
        r = '0;
        if (d > LAST_GOOD_DRAW)
        begin
            // The point stays put and only the flag is raised.
            r.bad = 1'b1;
        end
        else
        begin
            // Thresholds are tested in priority order, first hit wins.
            if (d < lim_stem)
                r.mp = ifs_fern_pkg::MAP_STEM;
            else if (d < lim_main)
                r.mp = ifs_fern_pkg::MAP_MAIN;
            else if (d < lim_left)
                r.mp = ifs_fern_pkg::MAP_LEFT;
            else
                r.mp = ifs_fern_pkg::MAP_RIGHT;

            case (r.mp)
                ifs_fern_pkg::MAP_STEM:
                begin
                    ka = 0; kb = 0; kc = 0; kd = 3355443; kf = -2013266;
                end
                ifs_fern_pkg::MAP_MAIN:
                begin
                    ka = 14176748; kb = 587203; kc = -587203;
                    kd = 13757317; kf = 26843546;
                end
                ifs_fern_pkg::MAP_LEFT:
                begin
                    ka = 3355443; kb = -5200937; kc = 4278190;
                    kd = 4110418; kf = 4865393;
                end
                default:
                begin
                    ka = -2516582; kb = 4026532; kc = 4194304;
                    kd = 3355443; kf = 11408507;
                end
            endcase

            // The x offset is zero for every map.
            xs = pt_x;
            ys = pt_y;
            pt_x = q48_round(xs * ka + ys * kb);
            pt_y = q48_round(xs * kc + ys * kd + kf * Q24_ONE);

            // Pixel position of the new point; anything outside the window reads 0.
            xs = pt_x;
            ys = pt_y;
            cn = (xs + X_SHIFT) * ifs_fern_pkg::IMG_W;
            rn = ys * ifs_fern_pkg::IMG_H;
            if (cn >= 0 && rn >= 0)
            begin
                cq = cn / X_SPAN;
                rq = rn / Y_SPAN;
                if (cq < ifs_fern_pkg::IMG_W && rq < ifs_fern_pkg::IMG_H)
                begin
                    r.frame = 1'b1;
                    r.col = cq[10:0];
                    r.row = rq[9:0];
                end
            end
        end
        r.x = pt_x;
        r.y = pt_y;
        return r;
    endfunction

    // Mostly legal draws, with a tenth of them out of range.
    function automatic logic [6:0] pick_draw();
        if ($urandom_range(9) == 0)
            return 7'($urandom_range(127, 100));
        else
            return 7'($urandom_range(99, 0));
    endfunction

    // Send one draw request; called at a falling edge and returns at one.
    task automatic send_draw(input logic [6:0] d);
        if ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            draw <= 7'($urandom);
            do
                @(negedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        in_valid <= 1'b1;
        draw <= d;
        do
            @(posedge clk);
        while (!in_ready);
        pending_points.insert(pending_points.size(), fern_advance(d));
        @(negedge clk);
    endtask

    // Stop sending and wait until every outstanding request has its result.
    task automatic settle();
        in_valid <= 1'b0;
        while (pending_points.size() != 0)
            @(negedge clk);
    endtask

    // One register write; the caller lowers the write enable afterwards.
    task automatic write_reg(input ifs_fern_pkg::cfg_index_t idx, input logic [6:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        case (idx)
            ifs_fern_pkg::CFG_LIMIT_STEM: lim_stem = val;
            ifs_fern_pkg::CFG_LIMIT_MAIN: lim_main = val;
            ifs_fern_pkg::CFG_LIMIT_LEFT: lim_left = val;
            default: ;
        endcase
    endtask

    task automatic set_limits(input logic [6:0] s, input logic [6:0] m,
                              input logic [6:0] l);
        settle();
        write_reg(ifs_fern_pkg::CFG_LIMIT_STEM, s);
        write_reg(ifs_fern_pkg::CFG_LIMIT_MAIN, m);
        write_reg(ifs_fern_pkg::CFG_LIMIT_LEFT, l);
        cfg_we <= 1'b0;
    endtask

    // Reset thresholds: a bad draw on the reset point, then every boundary.
    task automatic test_reset_limits();
        logic [6:0] picks[11];
        picks = '{7'd127, 7'd0, 7'd1, 7'd2, 7'd85, 7'd86, 7'd92, 7'd93,
                  7'd99, 7'd100, 7'd64};
        send_idle_pct = 0;
        recv_stall_pct = 0;
        foreach (picks[i])
            send_draw(picks[i]);
    endtask

    // Extreme, oversized and out-of-order thresholds, and the unused index.
    task automatic test_limit_writes();
        set_limits(7'd0, 7'd0, 7'd0);
        send_draw(7'd0);
        send_draw(7'd99);
        set_limits(7'd100, 7'd100, 7'd100);
        send_draw(7'd0);
        send_draw(7'd99);
        set_limits(7'd127, 7'd127, 7'd127);
        send_draw(7'd99);
        set_limits(7'd50, 7'd20, 7'd10);
        send_draw(7'd10);
        send_draw(7'd60);
        send_draw(7'd55);
        // A write to the unused index must leave the thresholds alone.
        settle();
        write_reg(ifs_fern_pkg::CFG_UNUSED, 7'd0);
        cfg_we <= 1'b0;
        send_draw(7'd1);
        send_draw(7'd70);
    endtask

    // Long random runs under each idle pattern and several threshold sets.
    task automatic test_random_traffic();
        int         send_pcts[4];
        int         stall_pcts[4];
        logic [6:0] s, m, l;
        send_pcts = '{0, 49, 0, 31};
        stall_pcts = '{0, 0, 49, 31};
        for (int p = 0; p < 4; p++)
        begin
            send_idle_pct = send_pcts[p];
            recv_stall_pct = stall_pcts[p];
            for (int c = 0; c < 3; c++)
            begin
                case (c)
                    0:
                    begin
                        s = 7'd2; m = 7'd86; l = 7'd93;
                    end
                    1:
                    begin
                        s = 7'($urandom_range(20, 0));
                        m = 7'($urandom_range(100, s));
                        l = 7'($urandom_range(100, m));
                    end
                    default:
                    begin
                        s = 7'($urandom_range(127, 0));
                        m = 7'($urandom_range(127, 0));
                        l = 7'($urandom_range(127, 0));
                    end
                endcase
                set_limits(s, m, l);
                repeat (CHUNK_ITEMS)
                    send_draw(pick_draw());
            end
        end
    endtask

    // Receiver stalls at the current rate.
    always @(negedge clk)
        out_ready <= ($urandom_range(99) >= recv_stall_pct);

    // Compare each accepted result with the oldest predicted point.
    always @(posedge clk)
    begin
        fern_result_t got;
        fern_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            got = {point_x, point_y, map_used, pixel_col, pixel_row,
                   in_frame, bad_draw};
            results_seen++;
            if (pending_points.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("result %0d with no request pending: x=%h y=%h",
                             results_seen, point_x, point_y);
            end
            else
            begin
                want = pending_points.pop_front();
                if (got.x !== want.x || got.y !== want.y || got.mp !== want.mp ||
                    got.col !== want.col || got.row !== want.row ||
                    got.frame !== want.frame || got.bad !== want.bad)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                    begin
                        $display("result %0d expected x=%h y=%h map=%0d col=%0d row=%0d f=%b b=%b",
                                 results_seen, want.x, want.y, want.mp, want.col,
                                 want.row, want.frame, want.bad);
                        $display("result %0d actual   x=%h y=%h map=%0d col=%0d row=%0d f=%b b=%b",
                                 results_seen, got.x, got.y, got.mp, got.col,
                                 got.row, got.frame, got.bad);
                    end
                end
            end
        end
    end

    // Watchdog on the cycle count.
    initial
    begin
        while (cycle_count < RUN_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("ifs_fern_point_step_core: mismatch");
        $finish;
    end

    initial
    begin
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_reset_limits();
        test_limit_writes();
        test_random_traffic();
        settle();
        repeat (TAIL_CYCLES) @(negedge clk);
        if (mismatches == 0 && pending_points.size() == 0)
            $display("ifs_fern_point_step_core: match");
        else
            $display("ifs_fern_point_step_core: mismatch");
        $finish;
    end

endmodule

// ===== ifs_fern_point_step_core.f =====
+incdir+hw/rtl
hw/rtl/ifs_fern_pkg.sv
hw/rtl/ifs_fern_point_step_core.sv
bench/ifs_fern_point_step_core_tb.sv
